// ===== hw/rtl/vang_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vang_pkg
// Types, widths and constants shared by the 3D vector angle pipeline.
// ----------------------------------------------------------------------------
package vang_pkg;

  localparam int CompWidth     = 16;
  localparam int AngleFracBits = 14;
  localparam int AngleWidth    = AngleFracBits + 2;

  localparam int RedWidth   = 16;
  localparam int ProdWidth  = 2 * RedWidth;
  localparam int DotWidth   = ProdWidth + 2;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int RadWidth   = 64;
  localparam int RootWidth  = RadWidth / 2;
  localparam int AbsdWidth  = 32;
  localparam int XWidth     = 34;
  localparam int CordWidth  = 36;
  localparam int ZWidth     = 34;
  localparam int Iterations = 31;

  localparam int FrontDepth  = 8;
  localparam int SqrtDepth   = RootWidth;
  localparam int CordicDepth = Iterations + 2;

  localparam logic signed [ZWidth-1:0] Q30HalfPi = 34'sh06487ED51;
  localparam logic signed [ZWidth-1:0] Q30Pi     = 34'sh0C90FDAA2;

  localparam longint AngleMax = (AngleFracBits >= 30) ? 64'hC90FDAA2 :
      ((64'hC90FDAA2 + (64'd1 << (29 - AngleFracBits))) >> (30 - AngleFracBits));

  typedef struct packed {
    logic signed [CompWidth-1:0] first_x;
    logic signed [CompWidth-1:0] first_y;
    logic signed [CompWidth-1:0] first_z;
    logic signed [CompWidth-1:0] second_x;
    logic signed [CompWidth-1:0] second_y;
    logic signed [CompWidth-1:0] second_z;
  } in_t;

  typedef struct packed {
    logic [AngleWidth-1:0] angle;
    logic                  zero_length;
  } out_t;

  typedef struct packed {
    logic                     zero;
    logic signed [XWidth-1:0] x;
    logic [RadWidth-1:0]      rad;
  } sqrt_in_t;

  typedef struct packed {
    logic                     zero;
    logic signed [XWidth-1:0] x;
    logic [RootWidth-1:0]     root;
  } cordic_in_t;

  function automatic logic signed [ZWidth-1:0] atan_q30(input int i);
    logic signed [ZWidth-1:0] t;
    case (i)
      0: t = 34'sh03243F6A8;
      1: t = 34'sh01DAC6705;
      2: t = 34'sh00FADBAFC;
      3: t = 34'sh007F56EA6;
      4: t = 34'sh003FEAB76;
      5: t = 34'sh001FFD55B;
      6: t = 34'sh000FFFAAA;
      7: t = 34'sh0007FFF55;
      8: t = 34'sh0003FFFEA;
      9: t = 34'sh0001FFFFD;
      default: t = (i > 30) ? '0 : ZWidth'((64'sd1 <<< (30 - i)) - 64'sd1);
    endcase
    return t;
  endfunction

  function automatic logic [6:0] bit_len(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [2:0][RedWidth-1:0] reduce3(
      input logic [2:0][CompWidth-1:0] c);
    logic [2:0][RedWidth-1:0] r;
    int                       len;
    int                       s;
    logic signed [63:0]       ext;
    s = 0;
    for (int j = 0; j < 3; j++) begin
      len = 1;
      for (int i = 0; i < CompWidth; i++) begin
        if (c[j][i] != c[j][CompWidth-1]) len = i + 2;
      end
      if (len - RedWidth > s) s = len - RedWidth;
    end
    for (int j = 0; j < 3; j++) begin
      ext = 64'(signed'(c[j]));
      ext = ext >>> s;
      r[j] = ext[RedWidth-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/vang_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vang_front
// Reduction, dot and cross products, squared cross norm and range scaling.
// ----------------------------------------------------------------------------
module vang_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  vang_pkg::in_t      operands,
  output logic               out_valid,
  output vang_pkg::sqrt_in_t out_data
);

  localparam int W  = vang_pkg::CompWidth;
  localparam int RW = vang_pkg::RedWidth;
  localparam int PW = vang_pkg::ProdWidth;
  localparam int DW = vang_pkg::DotWidth;
  localparam int CW = vang_pkg::CrossWidth;

  logic [vang_pkg::FrontDepth-1:0] valid;
  logic [vang_pkg::FrontDepth-1:0] zero;

  logic [2:0][W-1:0]  a1, b1;
  logic [2:0][RW-1:0] a2, b2;
  logic signed [PW-1:0] p00, p11, p22, p12, p21, p20, p02, p01, p10;
  logic signed [DW-1:0] dot4, dot5, dot6;
  logic signed [CW-1:0] cr0, cr1, cr2;
  logic [63:0] sq0, sq1, sq2;
  logic [vang_pkg::RadWidth-1:0] c2_6, c2_7;
  logic [vang_pkg::AbsdWidth-1:0] absd6, absd7;
  logic neg7;
  logic [4:0] k7;

  logic signed [2*CW-1:0] sq0_full, sq1_full, sq2_full;
  logic [6:0] lc, ld;
  int kc, kd, kk;

  assign sq0_full = cr0 * cr0;
  assign sq1_full = cr1 * cr1;
  assign sq2_full = cr2 * cr2;

  always_comb begin
    lc = vang_pkg::bit_len(c2_6);
    ld = vang_pkg::bit_len(64'(absd6));
    kc = (lc > 60) ? 0 : ((60 - int'(lc)) >> 1) + 1;
    kd = (ld > 30) ? 0 : 31 - int'(ld);
    kk = 30;
    if (kc < kk) kk = kc;
    if (kd < kk) kk = kd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[vang_pkg::FrontDepth-2:0], in_valid};
    end
    zero <= {zero[vang_pkg::FrontDepth-2:0],
             ((operands.first_x == '0) && (operands.first_y == '0) &&
              (operands.first_z == '0)) ||
             ((operands.second_x == '0) && (operands.second_y == '0) &&
              (operands.second_z == '0))};
    a1 <= {operands.first_z, operands.first_y, operands.first_x};
    b1 <= {operands.second_z, operands.second_y, operands.second_x};
    a2 <= vang_pkg::reduce3(a1);
    b2 <= vang_pkg::reduce3(b1);
    p00 <= signed'(a2[0]) * signed'(b2[0]);
    p11 <= signed'(a2[1]) * signed'(b2[1]);
    p22 <= signed'(a2[2]) * signed'(b2[2]);
    p12 <= signed'(a2[1]) * signed'(b2[2]);
    p21 <= signed'(a2[2]) * signed'(b2[1]);
    p20 <= signed'(a2[2]) * signed'(b2[0]);
    p02 <= signed'(a2[0]) * signed'(b2[2]);
    p01 <= signed'(a2[0]) * signed'(b2[1]);
    p10 <= signed'(a2[1]) * signed'(b2[0]);
    dot4 <= DW'(p00) + DW'(p11) + DW'(p22);
    cr0 <= CW'(p12) - CW'(p21);
    cr1 <= CW'(p20) - CW'(p02);
    cr2 <= CW'(p01) - CW'(p10);
    dot5 <= dot4;
    sq0 <= sq0_full[63:0];
    sq1 <= sq1_full[63:0];
    sq2 <= sq2_full[63:0];
    dot6 <= dot5;
    c2_6 <= sq0 + sq1 + sq2;
    absd6 <= dot5[DW-1] ? vang_pkg::AbsdWidth'(-dot5) : vang_pkg::AbsdWidth'(dot5);
    c2_7 <= c2_6;
    absd7 <= absd6;
    neg7 <= dot6[DW-1];
    k7 <= 5'(kk);
    out_data.rad <= c2_7 << {k7, 1'b0};
    out_data.x <= neg7 ? -(vang_pkg::XWidth'(absd7) << k7) : (vang_pkg::XWidth'(absd7) << k7);
    out_data.zero <= zero[vang_pkg::FrontDepth-2];
  end

  assign out_valid = valid[vang_pkg::FrontDepth-1];

endmodule

// ===== hw/rtl/vang_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vang_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vang_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  vang_pkg::sqrt_in_t   in_data,
  output logic                 out_valid,
  output vang_pkg::cordic_in_t out_data
);

  localparam int N   = vang_pkg::SqrtDepth;
  localparam int RTW = vang_pkg::RootWidth;
  localparam int RMW = RTW + 2;

  logic [N:0]                  valid;
  logic [N:0]                  zero;
  logic signed [vang_pkg::XWidth-1:0] x    [N+1];
  logic [vang_pkg::RadWidth-1:0]      rad  [N+1];
  logic [RMW-1:0]              rem  [N+1];
  logic [RTW-1:0]              root [N+1];

  assign valid[0] = in_valid;
  assign zero[0]  = in_data.zero;
  assign x[0]     = in_data.x;
  assign rad[0]   = in_data.rad;
  assign rem[0]   = '0;
  assign root[0]  = '0;

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [RMW+1:0] rem_n;
    logic [RMW+1:0] trial;
    assign rem_n = {rem[s], rad[s][vang_pkg::RadWidth-1 -: 2]};
    assign trial = {2'b00, root[s], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else begin
        valid[s+1] <= valid[s];
      end
      zero[s+1] <= zero[s];
      x[s+1]    <= x[s];
      rad[s+1]  <= rad[s] << 2;
      if (rem_n >= trial) begin
        rem[s+1]  <= RMW'(rem_n - trial);
        root[s+1] <= {root[s][RTW-2:0], 1'b1};
      end else begin
        rem[s+1]  <= RMW'(rem_n);
        root[s+1] <= {root[s][RTW-2:0], 1'b0};
      end
    end
  end

  assign out_valid     = valid[N];
  assign out_data.zero = zero[N];
  assign out_data.x    = x[N];
  assign out_data.root = root[N];

endmodule

// ===== hw/rtl/vang_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vang_cordic
// Vectoring CORDIC atan2 with quadrant fold, clamp and output rounding.
// ----------------------------------------------------------------------------
module vang_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  vang_pkg::cordic_in_t in_data,
  output logic                 out_valid,
  output vang_pkg::out_t       out_data
);

  localparam int N  = vang_pkg::Iterations;
  localparam int CW = vang_pkg::CordWidth;
  localparam int ZW = vang_pkg::ZWidth;
  localparam int F  = vang_pkg::AngleFracBits;
  localparam int AW = vang_pkg::AngleWidth;

  logic [N:0] valid;
  logic [N:0] zero;
  logic signed [CW-1:0] x [N+1];
  logic signed [CW-1:0] y [N+1];
  logic signed [ZW-1:0] z [N+1];

  logic [31:0]   zc;
  logic [AW-1:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
    zero[0] <= in_data.zero;
    if (in_data.x < 0) begin
      x[0] <= CW'(signed'({1'b0, in_data.root}));
      y[0] <= -CW'(in_data.x);
      z[0] <= vang_pkg::Q30HalfPi;
    end else begin
      x[0] <= CW'(in_data.x);
      y[0] <= CW'(signed'({1'b0, in_data.root}));
      z[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
      zero[i+1] <= zero[i];
      if (y[i] >= 0) begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + vang_pkg::atan_q30(i);
      end else begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - vang_pkg::atan_q30(i);
      end
    end
  end

  always_comb begin
    if (z[N] < 0) begin
      zc = '0;
    end else if (z[N] > vang_pkg::Q30Pi) begin
      zc = vang_pkg::Q30Pi[31:0];
    end else begin
      zc = z[N][31:0];
    end
  end

  if (F >= 30) begin : g_full
    assign res = AW'(zc);
  end else begin : g_round
    logic [32:0] rsum;
    assign rsum = {1'b0, zc} + (33'd1 << (29 - F));
    assign res  = rsum[30-F +: AW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid[N];
    end
    out_data.zero_length <= zero[N];
    out_data.angle       <= zero[N] ? '0 : res;
  end

endmodule

// ===== hw/rtl/vector_angle_3d_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_3d_unit
// Angle between two 3D integer vectors, 0 to pi in unsigned Q2.14 radians.
// ----------------------------------------------------------------------------
// A beat of operands is taken at each rising edge with start high; busy is
// always low, so a new pair of vectors can enter in every cycle.
// The result beat appears on result for exactly one cycle with done high,
// in the order its operands entered. One beat per cycle is sustained; the
// front end, the 32-stage square-root pipeline and the CORDIC pipeline with
// its 31 iteration stages set the latency.
// A vector with all components zero gives angle 0 and zero_length set.
// Synchronous reset clears every valid bit, so no beat is delivered from
// operands taken before reset. The receiver cannot stall; it must take
// each result in the cycle that done marks.
// ----------------------------------------------------------------------------
module vector_angle_3d_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  vang_pkg::in_t  operands,
  output logic           done,
  output vang_pkg::out_t result
);

  localparam int Latency = vang_pkg::FrontDepth + vang_pkg::SqrtDepth +
                           vang_pkg::CordicDepth;

  logic                 front_valid;
  vang_pkg::sqrt_in_t   front_data;
  logic                 sqrt_valid;
  vang_pkg::cordic_in_t sqrt_data;

  assign busy = 1'b0;

  vang_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .operands (operands),
    .out_valid(front_valid),
    .out_data (front_data)
  );

  vang_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_data  (front_data),
    .out_valid(sqrt_valid),
    .out_data (sqrt_data)
  );

  vang_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sqrt_valid),
    .in_data  (sqrt_data),
    .out_valid(done),
    .out_data (result)
  );

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Latency))
    else $error("result beat without matching operand beat");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_length) |-> (result.angle == '0))
    else $error("zero-length result with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (64'(result.angle) <= vang_pkg::AngleMax))
    else $error("angle above pi");

endmodule

// ===== dv/tb_vector_angle_3d_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_angle_3d_unit
// Self-checking bench for the 3D vector angle pipeline. Operand beats come
// from a directed table and then from random vector pairs; every result beat
// is compared with the table's angle where a row gives one, else with one
// computed here by dot/cross products, integer square root and a vectoring CORDIC.
// ----------------------------------------------------------------------------
module tb_vector_angle_3d_unit;

  localparam int RandomBeats = 1630;
  localparam int Latency     = 73;
  localparam int StallLimit  = 2000;

  typedef struct {
    vang_pkg::in_t  ops;
    logic           known;
    vang_pkg::out_t want;
  } vec_row_t;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  vang_pkg::in_t  operands;
  logic           done;
  vang_pkg::out_t result;

  vang_pkg::out_t angle_queue[$];
  int   mismatches;
  int   stall_cycles;
  int   quiet_window;
  bit   timed_out;
  vec_row_t vec_rows[$];

  vector_angle_3d_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint arctan_step(input int i);
    longint head[10];
    head = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
             64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD};
    if (i < 10) return head[i];
    return (64'sd1 <<< (30 - i)) - 1;
  endfunction

  function automatic vang_pkg::out_t predict_angle(input vang_pkg::in_t v);
    vang_pkg::out_t r;
    longint a0, a1, a2, b0, b1, b2;
    longint d, x, y, z, t, xs, ys, cx, cy, cz;
    logic [63:0] c2, absd, rounded;
    int     k;
    a0 = v.first_x;  a1 = v.first_y;  a2 = v.first_z;
    b0 = v.second_x; b1 = v.second_y; b2 = v.second_z;
    r = '0;
    if ((a0 == 0 && a1 == 0 && a2 == 0) || (b0 == 0 && b1 == 0 && b2 == 0)) begin
      r.zero_length = 1'b1;
      return r;
    end
    d  = a0 * b0 + a1 * b1 + a2 * b2;
    cx = a1 * b2 - a2 * b1;
    cy = a2 * b0 - a0 * b2;
    cz = a0 * b1 - a1 * b0;
    c2 = cx * cx + cy * cy + cz * cz;
    absd = (d < 0) ? -d : d;
    k = 0;
    while (k < 30 && c2 < (64'd1 << (60 - 2 * k)) && absd < (64'd1 << (30 - k))) k++;
    y = int_sqrt(c2 << (2 * k));
    x = (d < 0) ? -longint'(absd << k) : longint'(absd << k);
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'h6487ED51;
    end
    for (int i = 0; i < 31; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += arctan_step(i);
      end else begin
        x -= ys; y += xs; z -= arctan_step(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 64'hC90FDAA2) z = 64'hC90FDAA2;
    rounded = (64'(z) + (64'd1 << (29 - vang_pkg::AngleFracBits))) >>
              (30 - vang_pkg::AngleFracBits);
    r.angle = rounded[vang_pkg::AngleWidth-1:0];
    return r;
  endfunction

  function automatic vec_row_t make_row(input logic signed [15:0] ax, ay, az, bx, by, bz,
                                        input logic known, input int want_angle,
                                        input logic want_zero);
    vec_row_t row;
    row.ops = '{ax, ay, az, bx, by, bz};
    row.known = known;
    row.want.angle = vang_pkg::AngleWidth'(want_angle);
    row.want.zero_length = want_zero;
    return row;
  endfunction

  function automatic logic signed [15:0] random_component();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 6)) - 16'sd3;
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(input vang_pkg::in_t v, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    operands <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    angle_queue.push_back(predict_angle(v));
  endtask

  always @(posedge clk) begin
    vang_pkg::out_t want;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if ((start && !busy) || done || angle_queue.size() == 0) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        timed_out = 1'b1;
      end
      if (done) begin
        if (angle_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", result);
        end else begin
          want = angle_queue.pop_front();
          if (result.angle !== want.angle || result.zero_length !== want.zero_length) begin
            mismatches++;
            if (mismatches <= 10) $display("angle mismatch: expected %p, got %p", want, result);
          end
        end
      end
    end
  end

  initial begin
    vang_pkg::in_t v;
    vec_row_t row;
    mismatches = 0;
    timed_out = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    operands = '0;
    vec_rows.push_back(make_row(0, 0, 0, 0, 0, 0, 1, 0, 1));
    vec_rows.push_back(make_row(0, 0, 0, 5, -3, 7, 1, 0, 1));
    vec_rows.push_back(make_row(1, 2, 3, 0, 0, 0, 1, 0, 1));
    vec_rows.push_back(make_row(1, 0, 0, 1, 0, 0, 1, 0, 0));
    vec_rows.push_back(make_row(1, 0, 0, -1, 0, 0, 1, 51472, 0));
    vec_rows.push_back(make_row(1, 0, 0, 0, 1, 0, 1, 25736, 0));
    vec_rows.push_back(make_row(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0));
    vec_rows.push_back(make_row(32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0));
    vec_rows.push_back(make_row(32767, -32768, 0, 32767, 32767, 0, 0, 0, 0));
    vec_rows.push_back(make_row(-32768, 0, 0, 0, 0, 32767, 0, 0, 0));
    vec_rows.push_back(make_row(-1, -1, -1, 1, 1, 1, 0, 0, 0));
    vec_rows.push_back(make_row(32767, 1, 0, 32767, 0, 1, 0, 0, 0));
    vec_rows.push_back(make_row(3, 4, 0, -4, 3, 1, 0, 0, 0));
    vec_rows.push_back(make_row(-21846, 21845, -1, 21845, -21846, 0, 0, 0, 0));
    vec_rows.push_back(make_row(1, 1, 0, -1, 0, 0, 0, 0, 0));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (vec_rows[i]) begin
      row = vec_rows[i];
      send_beat(row.ops, 1'b1);
      if (row.known) angle_queue[$] = row.want;
    end
    start <= 1'b0;
    while (angle_queue.size() != 0 && !timed_out) @(posedge clk);
    for (int n = 0; n < RandomBeats && !timed_out; n++) begin
      if (n % 400 == 0) begin
        start <= 1'b0;
        while (angle_queue.size() != 0 && !timed_out) @(posedge clk);
      end
      v.first_x  = random_component();
      v.first_y  = random_component();
      v.first_z  = random_component();
      v.second_x = random_component();
      v.second_y = random_component();
      v.second_z = random_component();
      if ($urandom_range(0, 9) == 0) v = {v.first_x, v.first_y, v.first_z,
                                         -v.first_x, -v.first_y, -v.first_z};
      send_beat(v, !(n >= 600 && n < 900));
    end
    start <= 1'b0;
    while (angle_queue.size() != 0 && !timed_out) @(posedge clk);
    quiet_window = 0;
    while (quiet_window < Latency + 10 && !timed_out) begin
      @(posedge clk);
      quiet_window++;
    end
    if (timed_out) begin
      $display("[vector_angle_3d_unit] ERROR");
    end else if (mismatches == 0 && angle_queue.size() == 0) begin
      $display("[vector_angle_3d_unit] OK");
    end else begin
      $display("[vector_angle_3d_unit] ERROR");
    end
    $finish;
  end

endmodule
